### src/point_bounds_and_distance_tracker_core_assert.svh
// assertion macros for the point bounds tracker checker
// needs a clk and rst_n in the scope of each use
`ifndef POINT_BOUNDS_AND_DISTANCE_TRACKER_CORE_ASSERT_SVH
`define POINT_BOUNDS_AND_DISTANCE_TRACKER_CORE_ASSERT_SVH

// property that must hold whenever the antecedent holds
`define PBDT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after the antecedent
`define PBDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pbdt_pkg.sv
// shared constants, types and helpers for the point bounds tracker
// used by the interfaces, the root unit and the top level
package pbdt_pkg;

    localparam int COORD_BITS = 24;
    localparam int SUM_BITS   = 2 * COORD_BITS;
    localparam int REM_BITS   = COORD_BITS + 1;
    localparam int ROOT_STEPS = COORD_BITS;
    localparam int STEP_BITS  = $clog2(ROOT_STEPS);
    localparam int SQ_TERMS   = 3;
    localparam int SEL_BITS   = $clog2(SQ_TERMS);

    typedef logic [COORD_BITS-1:0]        coord_t;
    typedef logic signed [COORD_BITS-1:0] scoord_t;
    typedef logic [SUM_BITS-1:0]          sum_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_LOAD
    } pbdt_state_t;

    localparam logic [SEL_BITS-1:0]  SEL_LAST  = SEL_BITS'(SQ_TERMS - 1);
    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(ROOT_STEPS - 1);

    function automatic longint unsigned isqrt_const(longint unsigned n);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned b;
        rem  = n;
        root = 0;
        b    = 64'h4000_0000_0000_0000;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
            begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    localparam coord_t  FULL_SCALE = coord_t'(64'd1 << (COORD_BITS - 1));
    localparam scoord_t COORD_MAX  = scoord_t'((64'd1 << (COORD_BITS - 1)) - 64'd1);
    localparam scoord_t COORD_MIN  = scoord_t'(64'd1 << (COORD_BITS - 1));
    localparam coord_t  DIST_RESET =
        coord_t'(isqrt_const(64'd3 << (2 * COORD_BITS - 2)));

    function automatic coord_t mag(scoord_t v);
        coord_t r;
        r = v[COORD_BITS-1] ? coord_t'(-v) : coord_t'(v);
        return r;
    endfunction

endpackage

### src/pbdt_if.sv
// valid/ready channel interfaces for points and bounds results
// depends on pbdt_pkg
interface pbdt_point_if;
    logic                   valid;
    logic                   ready;
    logic                   start_batch;
    pbdt_pkg::scoord_t      px;
    pbdt_pkg::scoord_t      py;
    pbdt_pkg::scoord_t      pz;

    modport source (output valid, start_batch, px, py, pz, input ready);
    modport sink (input valid, start_batch, px, py, pz, output ready);
endinterface

interface pbdt_bounds_if;
    logic                   valid;
    logic                   ready;
    pbdt_pkg::scoord_t      x_low;
    pbdt_pkg::scoord_t      x_high;
    pbdt_pkg::scoord_t      y_low;
    pbdt_pkg::scoord_t      y_high;
    logic                   depth_seen;
    pbdt_pkg::coord_t       depth_low;
    pbdt_pkg::coord_t       depth_high;
    pbdt_pkg::coord_t       dist_low;
    pbdt_pkg::coord_t       dist_high;
    pbdt_pkg::coord_t       view_range;

    modport source (output valid, x_low, x_high, y_low, y_high, depth_seen, depth_low,
                    depth_high, dist_low, dist_high, view_range, input ready);
    modport sink (input valid, x_low, x_high, y_low, y_high, depth_seen, depth_low,
                  depth_high, dist_low, dist_high, view_range, output ready);
endinterface

### src/pbdt_isqrt.sv
// bit-serial integer square root, two radicand bits per cycle
// depends on pbdt_pkg
module pbdt_isqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pbdt_pkg::sum_t    radicand,
    output logic              done,
    output pbdt_pkg::coord_t  root
);

    pbdt_pkg::sum_t                         rad_reg, rad_next;
    logic [pbdt_pkg::REM_BITS-1:0]          rem_reg, rem_next;
    pbdt_pkg::coord_t                       root_reg, root_next;
    logic [pbdt_pkg::STEP_BITS-1:0]         step_reg, step_next;
    logic                                   busy_reg, busy_next;
    logic                                   done_reg, done_next;
    logic [pbdt_pkg::REM_BITS+1:0]          rem_sh;
    logic [pbdt_pkg::REM_BITS+1:0]          trial;

    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[pbdt_pkg::SUM_BITS-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = rad_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_next  = pbdt_pkg::REM_BITS'(rem_sh - trial);
                root_next = {root_reg[pbdt_pkg::COORD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = pbdt_pkg::REM_BITS'(rem_sh);
                root_next = {root_reg[pbdt_pkg::COORD_BITS-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == pbdt_pkg::STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### src/point_bounds_and_distance_tracker_core.sv
// point bounds and distance tracker, top level
// depends on pbdt_pkg, pbdt_if and pbdt_isqrt
//
// points (sink): one beat per 3d point, signed q12.12 px, py, pz plus
//   start_batch, which clears every accumulator before the point is applied
// bounds (source): one beat per point with running x/y min and max, depth
//   min and max over points with negative z, distance min and max, and the
//   display range (full scale until a depth point has been seen)
// an item passes from accept through the shared squarer that sums x^2+y^2+z^2
//   term by term, the bit-serial square root (one root bit per cycle), its
//   done strobe and a load into the output register
// a new point is taken only after the previous one is loaded; the next point
//   may be accepted while the previous result still waits in the output register
// a stalled receiver holds the result stable; once a second result is ready
//   the block waits in the load state until the output register frees
// reset clears all accumulators to their empty-batch values and drops valid
module point_bounds_and_distance_tracker_core (
    input  logic           clk,
    input  logic           rst_n,
    pbdt_point_if.sink     points,
    pbdt_bounds_if.source  bounds
);

    pbdt_pkg::pbdt_state_t          state_reg, state_next;
    logic [pbdt_pkg::SEL_BITS-1:0]  sel_reg, sel_next;
    logic                           accept;
    logic                           sq_start;
    logic                           load;
    logic                           root_done;
    pbdt_pkg::coord_t               root;

    pbdt_pkg::scoord_t  min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    pbdt_pkg::scoord_t  min_x_next, max_x_next, min_y_next, max_y_next;
    pbdt_pkg::scoord_t  bmin_x, bmax_x, bmin_y, bmax_y;
    pbdt_pkg::coord_t   min_depth_reg, max_depth_reg, min_depth_next, max_depth_next;
    pbdt_pkg::coord_t   bmin_depth, bmax_depth, dz;
    logic               any_depth_reg, any_depth_next, bany_depth, z_neg;
    pbdt_pkg::coord_t   min_dist_reg, max_dist_reg, dist_low_next, dist_high_next;
    pbdt_pkg::coord_t   ax_reg, ay_reg, az_reg, op;
    pbdt_pkg::sum_t     sq, sum_reg, sum_next;
    pbdt_pkg::coord_t   range_reg, range_next, mx_a, mx_b, mx_y;
    pbdt_pkg::coord_t   view_next;
    logic               out_valid_reg, out_valid_next;

    pbdt_pkg::scoord_t  o_x_low_reg, o_x_high_reg, o_y_low_reg, o_y_high_reg;
    logic               o_depth_seen_reg;
    pbdt_pkg::coord_t   o_depth_low_reg, o_depth_high_reg;
    pbdt_pkg::coord_t   o_dist_low_reg, o_dist_high_reg, o_view_reg;

    // control
    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        points.ready = 1'b0;
        sq_start     = 1'b0;
        load         = 1'b0;
        unique case (state_reg)
            pbdt_pkg::ST_IDLE:
            begin
                points.ready = 1'b1;
                sel_next     = '0;
                if (points.valid)
                    state_next = pbdt_pkg::ST_SQUARE;
            end
            pbdt_pkg::ST_SQUARE:
            begin
                sel_next = sel_reg + 1'b1;
                if (sel_reg == pbdt_pkg::SEL_LAST)
                begin
                    sq_start   = 1'b1;
                    state_next = pbdt_pkg::ST_ROOT;
                end
            end
            pbdt_pkg::ST_ROOT:
            begin
                if (root_done)
                    state_next = pbdt_pkg::ST_LOAD;
            end
            pbdt_pkg::ST_LOAD:
            begin
                if (!out_valid_reg || bounds.ready)
                begin
                    load       = 1'b1;
                    state_next = pbdt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pbdt_pkg::ST_IDLE;
            end
        endcase
    end

    assign accept = points.valid && points.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbdt_pkg::ST_IDLE;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // bound updates at accept
    always_comb
    begin
        bmin_x     = points.start_batch ? pbdt_pkg::COORD_MAX : min_x_reg;
        bmax_x     = points.start_batch ? pbdt_pkg::COORD_MIN : max_x_reg;
        bmin_y     = points.start_batch ? pbdt_pkg::COORD_MAX : min_y_reg;
        bmax_y     = points.start_batch ? pbdt_pkg::COORD_MIN : max_y_reg;
        bmin_depth = points.start_batch ? pbdt_pkg::FULL_SCALE : min_depth_reg;
        bmax_depth = points.start_batch ? '0 : max_depth_reg;
        bany_depth = points.start_batch ? 1'b0 : any_depth_reg;

        min_x_next = (points.px < bmin_x) ? points.px : bmin_x;
        max_x_next = (points.px > bmax_x) ? points.px : bmax_x;
        min_y_next = (points.py < bmin_y) ? points.py : bmin_y;
        max_y_next = (points.py > bmax_y) ? points.py : bmax_y;

        z_neg          = points.pz[pbdt_pkg::COORD_BITS-1];
        dz             = pbdt_pkg::mag(points.pz);
        min_depth_next = (z_neg && dz < bmin_depth) ? dz : bmin_depth;
        max_depth_next = (z_neg && dz > bmax_depth) ? dz : bmax_depth;
        any_depth_next = bany_depth | z_neg;
    end

    // squarer, range reduction and distance bounds
    always_comb
    begin
        unique case (sel_reg)
            2'd0:    op = ax_reg;
            2'd1:    op = ay_reg;
            default: op = az_reg;
        endcase
        sq       = pbdt_pkg::SUM_BITS'(op) * pbdt_pkg::SUM_BITS'(op);
        sum_next = (sel_reg == '0) ? sq : sum_reg + sq;

        mx_a = pbdt_pkg::mag(min_x_reg);
        mx_b = pbdt_pkg::mag(max_x_reg);
        mx_y = pbdt_pkg::mag(max_y_reg);
        unique case (sel_reg)
            2'd0:    range_next = (mx_b > mx_a) ? mx_b : mx_a;
            2'd1:    range_next = (mx_y > range_reg) ? mx_y : range_reg;
            default: range_next = (min_depth_reg > range_reg) ? min_depth_reg : range_reg;
        endcase

        dist_low_next  = (root < min_dist_reg) ? root : min_dist_reg;
        dist_high_next = (root > max_dist_reg) ? root : max_dist_reg;
        view_next      = any_depth_reg ? range_reg : pbdt_pkg::FULL_SCALE;

        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (bounds.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg     <= pbdt_pkg::COORD_MAX;
            max_x_reg     <= pbdt_pkg::COORD_MIN;
            min_y_reg     <= pbdt_pkg::COORD_MAX;
            max_y_reg     <= pbdt_pkg::COORD_MIN;
            min_depth_reg <= pbdt_pkg::FULL_SCALE;
            max_depth_reg <= '0;
            any_depth_reg <= 1'b0;
            min_dist_reg  <= pbdt_pkg::DIST_RESET;
            max_dist_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                min_x_reg     <= min_x_next;
                max_x_reg     <= max_x_next;
                min_y_reg     <= min_y_next;
                max_y_reg     <= max_y_next;
                min_depth_reg <= min_depth_next;
                max_depth_reg <= max_depth_next;
                any_depth_reg <= any_depth_next;
                if (points.start_batch)
                begin
                    min_dist_reg <= pbdt_pkg::DIST_RESET;
                    max_dist_reg <= '0;
                end
            end
            else if (load)
            begin
                min_dist_reg <= dist_low_next;
                max_dist_reg <= dist_high_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg <= pbdt_pkg::mag(points.px);
            ay_reg <= pbdt_pkg::mag(points.py);
            az_reg <= pbdt_pkg::mag(points.pz);
        end
        if (state_reg == pbdt_pkg::ST_SQUARE)
        begin
            sum_reg   <= sum_next;
            range_reg <= range_next;
        end
        if (load)
        begin
            o_x_low_reg      <= min_x_reg;
            o_x_high_reg     <= max_x_reg;
            o_y_low_reg      <= min_y_reg;
            o_y_high_reg     <= max_y_reg;
            o_depth_seen_reg <= any_depth_reg;
            o_depth_low_reg  <= min_depth_reg;
            o_depth_high_reg <= max_depth_reg;
            o_dist_low_reg   <= dist_low_next;
            o_dist_high_reg  <= dist_high_next;
            o_view_reg       <= view_next;
        end
    end

    pbdt_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sum_next),
        .done     (root_done),
        .root     (root)
    );

    assign bounds.valid      = out_valid_reg;
    assign bounds.x_low      = o_x_low_reg;
    assign bounds.x_high     = o_x_high_reg;
    assign bounds.y_low      = o_y_low_reg;
    assign bounds.y_high     = o_y_high_reg;
    assign bounds.depth_seen = o_depth_seen_reg;
    assign bounds.depth_low  = o_depth_low_reg;
    assign bounds.depth_high = o_depth_high_reg;
    assign bounds.dist_low   = o_dist_low_reg;
    assign bounds.dist_high  = o_dist_high_reg;
    assign bounds.view_range = o_view_reg;

endmodule

### src/pbdt_checker.sv
// port-level checks for the point bounds tracker, bound to the top level
// depends on pbdt_pkg and the assertion macro header
`include "point_bounds_and_distance_tracker_core_assert.svh"

module pbdt_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  pbdt_pkg::scoord_t  x_low,
    input  pbdt_pkg::scoord_t  x_high,
    input  pbdt_pkg::scoord_t  y_low,
    input  pbdt_pkg::scoord_t  y_high,
    input  logic               depth_seen,
    input  pbdt_pkg::coord_t   depth_low,
    input  pbdt_pkg::coord_t   depth_high,
    input  pbdt_pkg::coord_t   dist_low,
    input  pbdt_pkg::coord_t   dist_high,
    input  pbdt_pkg::coord_t   view_range
);

    // one point at a time through the squarer and root
    `PBDT_ASSERT_NEXT(a_no_back_to_back, in_valid && in_ready, !in_ready,
        "point accepted in consecutive cycles")

    // every result covers at least one point
    `PBDT_ASSERT_NOW(a_bounds_ordered, out_valid,
        x_low <= x_high && y_low <= y_high && dist_low <= dist_high,
        "low bound above high bound")

    // empty depth set reads fixed values and full-scale range
    `PBDT_ASSERT_NOW(a_no_depth_values, out_valid && !depth_seen,
        view_range == pbdt_pkg::FULL_SCALE && depth_low == pbdt_pkg::FULL_SCALE &&
        depth_high == '0,
        "depth-free result not at fixed values")

    `PBDT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(dist_low) && $stable(view_range),
        "stalled result beat changed")

endmodule

bind point_bounds_and_distance_tracker_core pbdt_checker u_pbdt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (points.valid),
    .in_ready   (points.ready),
    .out_valid  (bounds.valid),
    .out_ready  (bounds.ready),
    .x_low      (bounds.x_low),
    .x_high     (bounds.x_high),
    .y_low      (bounds.y_low),
    .y_high     (bounds.y_high),
    .depth_seen (bounds.depth_seen),
    .depth_low  (bounds.depth_low),
    .depth_high (bounds.depth_high),
    .dist_low   (bounds.dist_low),
    .dist_high  (bounds.dist_high),
    .view_range (bounds.view_range)
);

### verif/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for point_bounds_and_distance_tracker_core: random and directed points,
// running bounds predicted per accepted beat and compared against every result beat
// depends on pbdt_pkg, pbdt_if and the rtl of the tracker core
module testbench;
    import pbdt_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int TAIL_CYCLES  = 40;
    localparam int PHASE_POINTS = 325;

    typedef struct {
        logic    start_batch;
        scoord_t px;
        scoord_t py;
        scoord_t pz;
    } point_t;

    typedef struct {
        scoord_t x_low;
        scoord_t x_high;
        scoord_t y_low;
        scoord_t y_high;
        logic    depth_seen;
        coord_t  depth_low;
        coord_t  depth_high;
        coord_t  dist_low;
        coord_t  dist_high;
        coord_t  view_range;
    } bounds_t;

    logic clk;
    logic rst_n;

    pbdt_point_if  points_ch ();
    pbdt_bounds_if bounds_ch ();

    point_t  pending_points[$];
    bounds_t expected_bounds[$];
    point_t  next_point;
    bounds_t got_bounds;
    bounds_t want_bounds;

    int errors;
    int send_idle_pct;
    int recv_stall_pct;

    scoord_t trk_min_x;
    scoord_t trk_max_x;
    scoord_t trk_min_y;
    scoord_t trk_max_y;
    coord_t  trk_min_depth;
    coord_t  trk_max_depth;
    logic    trk_any_depth;
    coord_t  trk_min_dist;
    coord_t  trk_max_dist;

    point_bounds_and_distance_tracker_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (points_ch),
        .bounds (bounds_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic coord_t abs_code(scoord_t v);
        longint wide;
        wide = longint'(v);
        if (wide < 0)
            wide = -wide;
        return coord_t'(wide);
    endfunction

    // truncated root, one trial bit at a time from the top
    function automatic coord_t root_floor(longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = COORD_BITS - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return coord_t'(root);
    endfunction

    function automatic void clear_tracks();
        trk_min_x     = COORD_MAX;
        trk_max_x     = COORD_MIN;
        trk_min_y     = COORD_MAX;
        trk_max_y     = COORD_MIN;
        trk_min_depth = FULL_SCALE;
        trk_max_depth = '0;
        trk_any_depth = 1'b0;
        trk_min_dist  = DIST_RESET;
        trk_max_dist  = '0;
    endfunction

    function automatic bounds_t track_point(logic start, scoord_t x, scoord_t y, scoord_t z);
        bounds_t         r;
        coord_t          dz;
        coord_t          root_code;
        coord_t          range;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned az;
        if (start)
            clear_tracks();
        if (x < trk_min_x)
            trk_min_x = x;
        if (x > trk_max_x)
            trk_max_x = x;
        if (y < trk_min_y)
            trk_min_y = y;
        if (y > trk_max_y)
            trk_max_y = y;
        if (z < 0)
        begin
            dz = abs_code(z);
            if (dz < trk_min_depth)
                trk_min_depth = dz;
            if (dz > trk_max_depth)
                trk_max_depth = dz;
            trk_any_depth = 1'b1;
        end
        ax = abs_code(x);
        ay = abs_code(y);
        az = abs_code(z);
        root_code = root_floor(ax * ax + ay * ay + az * az);
        if (root_code < trk_min_dist)
            trk_min_dist = root_code;
        if (root_code > trk_max_dist)
            trk_max_dist = root_code;
        if (trk_any_depth)
        begin
            range = abs_code(trk_min_x);
            if (abs_code(trk_max_x) > range)
                range = abs_code(trk_max_x);
            if (abs_code(trk_max_y) > range)
                range = abs_code(trk_max_y);
            if (trk_min_depth > range)
                range = trk_min_depth;
        end
        else
        begin
            range = FULL_SCALE;
        end
        r.x_low      = trk_min_x;
        r.x_high     = trk_max_x;
        r.y_low      = trk_min_y;
        r.y_high     = trk_max_y;
        r.depth_seen = trk_any_depth;
        r.depth_low  = trk_min_depth;
        r.depth_high = trk_max_depth;
        r.dist_low   = trk_min_dist;
        r.dist_high  = trk_max_dist;
        r.view_range = range;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [COORD_BITS-1:0] want,
                               input logic [COORD_BITS-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t bounds %s: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // driver, with the predictor run on each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_ch.valid       <= 1'b0;
            points_ch.start_batch <= 1'b0;
            points_ch.px          <= '0;
            points_ch.py          <= '0;
            points_ch.pz          <= '0;
            clear_tracks();
        end
        else
        begin
            if (points_ch.valid && points_ch.ready)
                expected_bounds.push_back(track_point(points_ch.start_batch, points_ch.px,
                                                      points_ch.py, points_ch.pz));
            if (!points_ch.valid || points_ch.ready)
            begin
                if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_point = pending_points.pop_front();
                    points_ch.valid       <= 1'b1;
                    points_ch.start_batch <= next_point.start_batch;
                    points_ch.px          <= next_point.px;
                    points_ch.py          <= next_point.py;
                    points_ch.pz          <= next_point.pz;
                end
                else
                begin
                    points_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bounds_ch.ready <= 1'b0;
        else
            bounds_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && bounds_ch.valid && bounds_ch.ready)
        begin
            if (expected_bounds.size() == 0)
            begin
                errors++;
                $display("%0t bounds beat with no prediction waiting", $time);
            end
            else
            begin
                want_bounds = expected_bounds.pop_front();
                got_bounds.x_low      = bounds_ch.x_low;
                got_bounds.x_high     = bounds_ch.x_high;
                got_bounds.y_low      = bounds_ch.y_low;
                got_bounds.y_high     = bounds_ch.y_high;
                got_bounds.depth_seen = bounds_ch.depth_seen;
                got_bounds.depth_low  = bounds_ch.depth_low;
                got_bounds.depth_high = bounds_ch.depth_high;
                got_bounds.dist_low   = bounds_ch.dist_low;
                got_bounds.dist_high  = bounds_ch.dist_high;
                got_bounds.view_range = bounds_ch.view_range;
                check_field("x_low", want_bounds.x_low, got_bounds.x_low);
                check_field("x_high", want_bounds.x_high, got_bounds.x_high);
                check_field("y_low", want_bounds.y_low, got_bounds.y_low);
                check_field("y_high", want_bounds.y_high, got_bounds.y_high);
                check_field("depth_seen", COORD_BITS'(want_bounds.depth_seen),
                            COORD_BITS'(got_bounds.depth_seen));
                check_field("depth_low", want_bounds.depth_low, got_bounds.depth_low);
                check_field("depth_high", want_bounds.depth_high, got_bounds.depth_high);
                check_field("dist_low", want_bounds.dist_low, got_bounds.dist_low);
                check_field("dist_high", want_bounds.dist_high, got_bounds.dist_high);
                check_field("view_range", want_bounds.view_range, got_bounds.view_range);
            end
        end
    end

    task automatic push_point(input logic start, input scoord_t x, input scoord_t y,
                              input scoord_t z);
        point_t p;
        p.start_batch = start;
        p.px = x;
        p.py = y;
        p.pz = z;
        pending_points.push_back(p);
    endtask

    // 0 full range, 1 near origin, 2 corner codes, 3 mixed per coordinate
    function automatic scoord_t pick_coord(int style);
        int      k;
        scoord_t v;
        k = (style == 3) ? $urandom_range(2) : style;
        case (k)
            0: v = scoord_t'($urandom);
            1: v = scoord_t'(int'($urandom_range(255)) - 128);
            default:
            begin
                case ($urandom_range(4))
                    0: v = COORD_MIN;
                    1: v = COORD_MAX;
                    2: v = '0;
                    3: v = scoord_t'(-1);
                    default: v = scoord_t'(1);
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic add_random_points(input int count);
        int     left;
        int     batch_len;
        int     style;
        bit     no_depth;
        point_t p;
        left = count;
        while (left > 0)
        begin
            batch_len = $urandom_range(40, 1);
            if (batch_len > left)
                batch_len = left;
            style    = $urandom_range(3);
            no_depth = ($urandom_range(3) == 0);
            for (int i = 0; i < batch_len; i++)
            begin
                p.start_batch = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0);
                p.px = pick_coord(style);
                p.py = pick_coord(style);
                p.pz = pick_coord(style);
                if (no_depth && p.pz < 0)
                    p.pz = ~p.pz;
                pending_points.push_back(p);
            end
            left -= batch_len;
        end
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0 || points_ch.valid || expected_bounds.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        add_random_points(PHASE_POINTS);
        wait_drained();
    endtask

    initial
    begin
        errors                = 0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // no start after reset, then corners, zero point and depth edge cases
        push_point(1'b0, 1, 2, 3);
        push_point(1'b0, -5, 7, -100);
        push_point(1'b0, COORD_MIN, COORD_MAX, COORD_MIN);
        push_point(1'b0, COORD_MAX, COORD_MIN, 0);
        push_point(1'b1, 0, 0, 0);
        push_point(1'b0, 0, 0, -1);
        push_point(1'b1, COORD_MIN, COORD_MIN, COORD_MIN);
        push_point(1'b1, COORD_MAX, COORD_MAX, COORD_MAX);
        push_point(1'b1, -1, -1, -1);
        push_point(1'b0, 1, 1, 1);
        push_point(1'b1, 100, -200, 300);
        push_point(1'b0, -300, 50, 10);
        push_point(1'b1, COORD_MAX, 0, -2);
        push_point(1'b0, 0, COORD_MAX, -COORD_MAX);
        push_point(1'b1, 24'sh001000, 24'sh002000, -24'sh003000);
        push_point(1'b0, 24'sh555555, 24'shAAAAAA, -24'sh155555);
        push_point(1'b1, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA);
        push_point(1'b0, COORD_MIN, 0, COORD_MAX);
        wait_drained();

        run_phase(0, 0);
        run_phase(84, 0);
        run_phase(0, 84);
        run_phase(31, 31);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #(64'd8_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
